### hdl/mtcd_pkg.sv
// ----------------------------------------------------------------------------
// mtcd_pkg
// Types, codes and constants shared by the time code decoder modules.
// ----------------------------------------------------------------------------
package mtcd_pkg;

	// request kinds
	localparam logic OP_QUARTER = 1'b0;
	localparam logic OP_SYSEX   = 1'b1;

	// rate codes
	localparam logic [1:0] RATE_24   = 2'd0;
	localparam logic [1:0] RATE_25   = 2'd1;
	localparam logic [1:0] RATE_2997 = 2'd2;
	localparam logic [1:0] RATE_30   = 2'd3;

	// full-frame header bytes
	localparam logic [7:0] SYX_START = 8'hF0;
	localparam logic [7:0] SYX_RT_ID = 8'h7F;
	localparam logic [7:0] SYX_SUB   = 8'h01;

	localparam logic [3:0] MSG_MIN_LEN = 4'd10;

	localparam int SECS_W = 17;
	localparam int NUM_W  = 17;
	localparam int FRAC_W = 11;
	localparam int MS_W   = 27;

	// reciprocal of twice the frame rate, rounded up
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = 19;
	localparam logic [RECIP_W-1:0] RECIP_48 = RECIP_W'(((1 << RECIP_SHIFT) + 47) / 48);
	localparam logic [RECIP_W-1:0] RECIP_50 = RECIP_W'(((1 << RECIP_SHIFT) + 49) / 50);
	localparam logic [RECIP_W-1:0] RECIP_60 = RECIP_W'(((1 << RECIP_SHIFT) + 59) / 60);

	typedef struct packed {
		logic       operation;
		logic [7:0] byte_value;
		logic       last_of_message;
	} item_t;

	typedef struct packed {
		logic        time_updated;
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic [4:0]  frames;
		logic [1:0]  rate_code;
		logic [26:0] position_ms;
		logic [4:0]  nominal_fps;
	} result_t;

	// decoded time after one request
	typedef struct packed {
		logic       updated;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic [4:0] frames;
		logic [1:0] rate;
		logic       offset;
	} tc_t;

endpackage

### hdl/midi_time_code_decoder.sv
// path: input register, state register, s3, s4, then the result register
// throughput: one request per cycle; the whole pipeline advances together and
// holds only while a waiting result is stalled
// reset: time clears to 00:00:00:00 at 30 fps with no offset, quarter-frame
// slots and seen marks clear, any partial full-frame message is dropped
// ----------------------------------------------------------------------------
// midi_time_code_decoder
// Decodes quarter-frame and full-frame time code bytes into the current time
// and its position in milliseconds.
// ----------------------------------------------------------------------------
module midi_time_code_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  mtcd_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output mtcd_pkg::result_t result
);
	import mtcd_pkg::*;

	logic  en;
	logic  valid_s2;
	tc_t   tc_s2;

	assign en         = !(result_valid && result_stall);
	assign item_stall = !en;

	mtcd_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (item_valid),
		.item      (item),
		.out_valid (valid_s2),
		.tc        (tc_s2)
	);

	mtcd_time u_time (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s2),
		.tc        (tc_s2),
		.out_valid (result_valid),
		.result    (result)
	);

endmodule

### hdl/mtcd_state.sv
// ----------------------------------------------------------------------------
// mtcd_state
// Input register and decoder state: quarter-frame slots, full-frame capture,
// and the current time registers.
// ----------------------------------------------------------------------------
module mtcd_state (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  mtcd_pkg::item_t   item,
	output logic              out_valid,
	output mtcd_pkg::tc_t     tc
);
	import mtcd_pkg::*;

	logic             valid_s1;
	item_t            item_s1;

	logic [7:0][3:0]  nib_q, nib_d;
	logic [7:0]       seen_q, seen_d;
	logic [3:0][7:0]  cap_q, cap_d;
	logic [3:0]       count_q, count_d;
	logic             hdr_q, hdr_d;
	logic [4:0]       hours_q, hours_d;
	logic [5:0]       minutes_q, minutes_d;
	logic [5:0]       seconds_q, seconds_d;
	logic [4:0]       frames_q, frames_d;
	logic [1:0]       rate_q, rate_d;
	logic             offset_q, offset_d;
	logic             upd;

	logic [2:0]       piece;
	logic [7:0]       b;

	assign b     = item_s1.byte_value;
	assign piece = b[6:4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		nib_d     = nib_q;
		seen_d    = seen_q;
		cap_d     = cap_q;
		count_d   = count_q;
		hdr_d     = hdr_q;
		hours_d   = hours_q;
		minutes_d = minutes_q;
		seconds_d = seconds_q;
		frames_d  = frames_q;
		rate_d    = rate_q;
		offset_d  = offset_q;
		upd       = 1'b0;
		if (item_s1.operation == OP_QUARTER) begin
			nib_d[piece] = b[3:0];
			seen_d = seen_q | (8'd1 << piece);
			if (piece == 3'd7 && seen_d[0]) begin
				frames_d  = {nib_d[1][0], nib_d[0]};
				seconds_d = {nib_d[3][1:0], nib_d[2]};
				minutes_d = {nib_d[5][1:0], nib_d[4]};
				hours_d   = {nib_d[7][0], nib_d[6]};
				rate_d    = nib_d[7][2:1];
				offset_d  = 1'b1;
				seen_d    = '0;
				upd       = 1'b1;
			end
		end else begin
			case (count_q) inside
				4'd0: hdr_d = (b == SYX_START);
				4'd1: if (b != SYX_RT_ID) hdr_d = 1'b0;
				4'd3, 4'd4: if (b != SYX_SUB) hdr_d = 1'b0;
				[4'd5:4'd8]: cap_d[2'(count_q - 4'd5)] = b;
				default: ;
			endcase
			if (count_q < MSG_MIN_LEN) begin
				count_d = count_q + 4'd1;
			end
			if (item_s1.last_of_message) begin
				if (count_d >= MSG_MIN_LEN && hdr_d) begin
					rate_d    = cap_d[0][6:5];
					hours_d   = cap_d[0][4:0];
					minutes_d = cap_d[1][5:0];
					seconds_d = cap_d[2][5:0];
					frames_d  = cap_d[3][4:0];
					offset_d  = 1'b0;
					seen_d    = '0;
					upd       = 1'b1;
				end
				count_d = '0;
				hdr_d   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nib_q     <= '0;
			seen_q    <= '0;
			count_q   <= '0;
			hdr_q     <= 1'b0;
			hours_q   <= '0;
			minutes_q <= '0;
			seconds_q <= '0;
			frames_q  <= '0;
			rate_q    <= RATE_30;
			offset_q  <= 1'b0;
		end else if (en && valid_s1) begin
			nib_q     <= nib_d;
			seen_q    <= seen_d;
			count_q   <= count_d;
			hdr_q     <= hdr_d;
			hours_q   <= hours_d;
			minutes_q <= minutes_d;
			seconds_q <= seconds_d;
			frames_q  <= frames_d;
			rate_q    <= rate_d;
			offset_q  <= offset_d;
		end
	end

	// capture bytes are always written before a load can read them
	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			cap_q <= cap_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tc.updated <= upd;
			tc.hours   <= hours_d;
			tc.minutes <= minutes_d;
			tc.seconds <= seconds_d;
			tc.frames  <= frames_d;
			tc.rate    <= rate_d;
			tc.offset  <= offset_d;
		end
	end

endmodule

### hdl/mtcd_time.sv
// ----------------------------------------------------------------------------
// mtcd_time
// Position in milliseconds from the decoded time, in three stages:
// seconds and fraction numerator, constant multiplies, final sum.
// ----------------------------------------------------------------------------
module mtcd_time (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  mtcd_pkg::tc_t     tc,
	output logic              out_valid,
	output mtcd_pkg::result_t result
);
	import mtcd_pkg::*;

	logic                        valid_s3, valid_s4;
	tc_t                         tc_s3, tc_s4;
	logic [SECS_W-1:0]           secs_s3;
	logic [NUM_W-1:0]            num_s3;
	logic [MS_W-1:0]             secs_ms_s4;
	logic [FRAC_W-1:0]           frac_s4;

	logic [5:0]                  k;
	logic [NUM_W-1:0]            per_frame;
	logic [NUM_W-1:0]            den2;
	logic [RECIP_W-1:0]          recip;
	logic [NUM_W+RECIP_W-1:0]    prod;
	logic [4:0]                  fps;

	assign k = {1'b0, tc.frames} + (tc.offset ? 6'd2 : 6'd0);

	always_comb begin
		case (tc.rate)
			RATE_24:   begin per_frame = NUM_W'(1000); den2 = NUM_W'(48); end
			RATE_25:   begin per_frame = NUM_W'(1000); den2 = NUM_W'(50); end
			RATE_2997: begin per_frame = NUM_W'(1001); den2 = NUM_W'(60); end
			default:   begin per_frame = NUM_W'(1000); den2 = NUM_W'(60); end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tc_s3   <= tc;
			secs_s3 <= SECS_W'(tc.hours) * SECS_W'(3600)
				+ SECS_W'(tc.minutes) * SECS_W'(60) + SECS_W'(tc.seconds);
			// 2*k*per_frame + den, so the quotient rounds half up
			num_s3  <= ((NUM_W'(k) * per_frame) << 1) + (den2 >> 1);
		end
	end

	always_comb begin
		case (tc_s3.rate)
			RATE_24: recip = RECIP_48;
			RATE_25: recip = RECIP_50;
			default: recip = RECIP_60;
		endcase
	end

	assign prod = (NUM_W+RECIP_W)'(num_s3) * (NUM_W+RECIP_W)'(recip);

	always_ff @(posedge clk) begin
		if (en) begin
			tc_s4      <= tc_s3;
			secs_ms_s4 <= MS_W'(secs_s3) * MS_W'(1000);
			frac_s4    <= prod[RECIP_SHIFT +: FRAC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s3  <= in_valid;
			valid_s4  <= valid_s3;
			out_valid <= valid_s4;
		end
	end

	always_comb begin
		case (tc_s4.rate)
			RATE_24: fps = 5'd24;
			RATE_25: fps = 5'd25;
			default: fps = 5'd30;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result.time_updated <= tc_s4.updated;
			result.hours        <= tc_s4.hours;
			result.minutes      <= tc_s4.minutes;
			result.seconds      <= tc_s4.seconds;
			result.frames       <= tc_s4.frames;
			result.rate_code    <= tc_s4.rate;
			result.position_ms  <= secs_ms_s4 + MS_W'(frac_s4);
			result.nominal_fps  <= fps;
		end
	end

endmodule

### test/tb_midi_time_code_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_time_code_decoder
// Drives quarter-frame and full-frame time code requests into the decoder,
// keeps its own copy of the decoded time and checks every result in order.
// ----------------------------------------------------------------------------
module tb_midi_time_code_decoder;
	import mtcd_pkg::*;

	localparam int ITEM_TARGET   = 500;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_REPORTS   = 20;
	localparam int NO_CORRUPTION = -1;
	localparam logic [7:0] SYX_END = 8'hF7;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// decoder state as the predictor sees it
	logic [3:0] qf_nibble [8];
	logic [7:0] qf_seen;
	logic [4:0] tc_hours;
	logic [5:0] tc_minutes;
	logic [5:0] tc_seconds;
	logic [4:0] tc_frames;
	logic [1:0] tc_rate;
	logic       tc_offset;
	logic [3:0] syx_count;
	logic       syx_header_ok;
	logic [7:0] syx_field [4];

	result_t pending_times [$];
	int      sent_count = 0;
	int      result_count = 0;
	int      error_count = 0;
	bit      idle_enable = 1'b1;
	bit      hold_results = 1'b0;

	midi_time_code_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void header_ok_clear();
		syx_header_ok = 1'b0;
	endfunction

	function automatic void clear_decoder_state();
		for (int i = 0; i < 8; i++)
			qf_nibble[i] = '0;
		for (int i = 0; i < 4; i++)
			syx_field[i] = '0;
		qf_seen       = '0;
		tc_hours      = '0;
		tc_minutes    = '0;
		tc_seconds    = '0;
		tc_frames     = '0;
		tc_rate       = RATE_30;
		tc_offset     = 1'b0;
		syx_count     = '0;
		header_ok_clear();
	endfunction

	// updates the decoder state for one request and returns the time it reports
	function automatic result_t decode_byte(item_t req);
		result_t           r;
		logic [2:0]        piece;
		longint unsigned   secs;
		longint unsigned   ticks;
		longint unsigned   num;
		longint unsigned   den;
		r = '0;
		if (req.operation == OP_QUARTER) begin
			piece = req.byte_value[6:4];
			qf_nibble[piece] = req.byte_value[3:0];
			qf_seen[piece] = 1'b1;
			if (piece == 3'd7 && qf_seen[0]) begin
				tc_frames  = {qf_nibble[1][0], qf_nibble[0]};
				tc_seconds = {qf_nibble[3][1:0], qf_nibble[2]};
				tc_minutes = {qf_nibble[5][1:0], qf_nibble[4]};
				tc_hours   = {qf_nibble[7][0], qf_nibble[6]};
				tc_rate    = qf_nibble[7][2:1];
				tc_offset  = 1'b1;
				qf_seen    = '0;
				r.time_updated = 1'b1;
			end
		end else begin
			case (syx_count)
				4'd0: syx_header_ok = (req.byte_value == SYX_START);
				4'd1: if (req.byte_value != SYX_RT_ID) syx_header_ok = 1'b0;
				4'd3, 4'd4: if (req.byte_value != SYX_SUB) syx_header_ok = 1'b0;
				4'd5, 4'd6, 4'd7, 4'd8: syx_field[syx_count - 4'd5] = req.byte_value;
				default: ;
			endcase
			if (syx_count < MSG_MIN_LEN)
				syx_count++;
			if (req.last_of_message) begin
				if (syx_count >= MSG_MIN_LEN && syx_header_ok) begin
					tc_rate    = syx_field[0][6:5];
					tc_hours   = syx_field[0][4:0];
					tc_minutes = syx_field[1][5:0];
					tc_seconds = syx_field[2][5:0];
					tc_frames  = syx_field[3][4:0];
					tc_offset  = 1'b0;
					qf_seen    = '0;
					r.time_updated = 1'b1;
				end
				syx_count = '0;
				syx_header_ok = 1'b0;
			end
		end

		secs  = longint'(tc_hours) * 3600 + longint'(tc_minutes) * 60 + longint'(tc_seconds);
		ticks = longint'(tc_frames) + (tc_offset ? 2 : 0);
		case (tc_rate)
			RATE_24:   begin num = ticks * 1000; den = 24; end
			RATE_25:   begin num = ticks * 1000; den = 25; end
			RATE_2997: begin num = ticks * 1001; den = 30; end
			default:   begin num = ticks * 1000; den = 30; end
		endcase
		r.hours       = tc_hours;
		r.minutes     = tc_minutes;
		r.seconds     = tc_seconds;
		r.frames      = tc_frames;
		r.rate_code   = tc_rate;
		// half up: floor((2*num + den) / (2*den))
		r.position_ms = 27'(secs * 1000 + (2 * num + den) / (2 * den));
		r.nominal_fps = (tc_rate == RATE_24) ? 5'd24 : (tc_rate == RATE_25) ? 5'd25 : 5'd30;
		return r;
	endfunction

	// mostly no gap, sometimes a few cycles, now and then a long one
	function automatic int gap_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("MISMATCH: %s", msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
				result_count, name, got, want));
	endtask

	task automatic send_request(input logic op, input logic [7:0] value, input logic last);
		item_t req;
		int    gap;
		req.operation       = op;
		req.byte_value      = value;
		req.last_of_message = last;
		item       <= req;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		pending_times.push_back(decode_byte(req));
		sent_count++;
		gap = idle_enable ? gap_length() : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_drain();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_times.size() != 0);
	endtask

	// eight pieces in running order, sometimes backwards, from an odd start or with a gap
	task automatic send_quarter_frame(input bit reverse);
		int         start;
		int         dropped;
		logic [2:0] piece;
		start   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
		dropped = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : 8;
		for (int i = 0; i < 8; i++) begin
			piece = reverse ? 3'(start - i) : 3'(start + i);
			if (int'(piece) != dropped)
				send_request(OP_QUARTER,
					{1'($urandom_range(0, 7) == 0), piece, 4'($urandom)}, 1'($urandom));
		end
	endtask

	task automatic send_full_frame(input int length, input int bad_pos);
		logic [7:0] b;
		for (int i = 0; i < length; i++) begin
			case (i)
				0: b = SYX_START;
				1: b = SYX_RT_ID;
				3, 4: b = SYX_SUB;
				9: b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : SYX_END;
				default: b = 8'($urandom);
			endcase
			if (i == bad_pos)
				b = b ^ 8'($urandom_range(1, 255));
			// a stray quarter frame inside the message
			if ($urandom_range(0, 29) == 0)
				send_request(OP_QUARTER, 8'($urandom), 1'($urandom));
			send_request(OP_SYSEX, b, i == length - 1);
		end
	endtask

	task automatic send_noise();
		bit   open_msg;
		logic op;
		logic last;
		open_msg = 1'b0;
		repeat ($urandom_range(1, 4)) begin
			op   = 1'($urandom);
			last = 1'($urandom);
			send_request(op, 8'($urandom), last);
			if (op == OP_SYSEX)
				open_msg = !last;
		end
		// close any message left open so the next one starts cleanly
		if (open_msg)
			send_request(OP_SYSEX, 8'($urandom), 1'b1);
	endtask

	task automatic test_quarter_frames();
		// piece 7 with nothing before it, top bit set
		send_request(OP_QUARTER, 8'hF5, 1'b1);
		for (int p = 0; p < 8; p++)
			send_request(OP_QUARTER, {p[0], 3'(p), 4'hF}, p[1]);
		send_request(OP_QUARTER, 8'h00, 1'b0);
		wait_for_drain();
	endtask

	task automatic test_full_frame();
		logic [7:0] frame [10];
		frame = '{SYX_START, SYX_RT_ID, 8'h00, SYX_SUB, SYX_SUB,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, SYX_END};
		for (int i = 0; i < 10; i++) begin
			if (i == 5)
				send_request(OP_QUARTER, 8'h3A, 1'b1);
			send_request(OP_SYSEX, frame[i], i == 9);
		end
		// the load cleared the seen marks, so this must not assemble
		send_request(OP_QUARTER, 8'h70, 1'b0);
		// one-byte message, too short to load
		send_request(OP_SYSEX, SYX_START, 1'b1);
		wait_for_drain();
	endtask

	task automatic test_backpressure();
		idle_enable  = 1'b0;
		hold_results = 1'b1;
		repeat (4) send_full_frame(10, NO_CORRUPTION);
		while (hold_results)
			@(posedge clk);
		wait_for_drain();
		idle_enable = 1'b1;
	endtask

	task automatic test_random_traffic();
		int kind;
		int idx;
		while (sent_count < ITEM_TARGET) begin
			if ($urandom_range(0, 7) == 0)
				idle_enable = !idle_enable;
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				send_quarter_frame($urandom_range(0, 4) == 0);
			end else if (kind < 7) begin
				send_full_frame($urandom_range(10, 12), NO_CORRUPTION);
			end else if (kind == 7) begin
				if ($urandom_range(0, 1) == 0) begin
					send_full_frame($urandom_range(1, 9), NO_CORRUPTION);
				end else begin
					// header bytes that are checked sit at 0, 1, 3 and 4
					idx = $urandom_range(0, 3);
					send_full_frame($urandom_range(10, 12), (idx < 2) ? idx : idx + 1);
				end
			end else begin
				send_noise();
			end
		end
		idle_enable = 1'b1;
		wait_for_drain();
	endtask

	// receiver side: random stalls, and one long hold when asked
	always begin : result_stall_gen
		if (hold_results) begin
			result_stall <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_results = 1'b0;
		end else if (idle_enable && $urandom_range(0, 2) == 0) begin
			result_stall <= 1'b1;
			repeat (gap_length() + 1) @(posedge clk);
		end else begin
			result_stall <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			result_count++;
			if (pending_times.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no request outstanding",
					result_count));
			end else begin
				want = pending_times.pop_front();
				check_field("time_updated", 32'(result.time_updated),
					32'(want.time_updated));
				check_field("hours", 32'(result.hours), 32'(want.hours));
				check_field("minutes", 32'(result.minutes), 32'(want.minutes));
				check_field("seconds", 32'(result.seconds), 32'(want.seconds));
				check_field("frames", 32'(result.frames), 32'(want.frames));
				check_field("rate_code", 32'(result.rate_code), 32'(want.rate_code));
				check_field("position_ms", 32'(result.position_ms),
					32'(want.position_ms));
				check_field("nominal_fps", 32'(result.nominal_fps),
					32'(want.nominal_fps));
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		clear_decoder_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_quarter_frames();
		test_full_frame();
		test_backpressure();
		test_random_traffic();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### midi_time_code_decoder.f
hdl/mtcd_pkg.sv
hdl/mtcd_state.sv
hdl/mtcd_time.sv
hdl/midi_time_code_decoder.sv
test/tb_midi_time_code_decoder.sv
